FILE: src/mlr_pkg.sv
// Shared constants, types and codes of the midpoint line rasteriser.
package mlr_pkg;

   localparam int COORD_BITS = 10;
   // Transformed coordinates need a sign bit and headroom for negation.
   localparam int WALK_BITS  = COORD_BITS + 2;
   localparam int DEC_BITS   = COORD_BITS + 4;

   typedef logic [COORD_BITS-1:0]      coord_type;
   typedef logic signed [WALK_BITS-1:0] walk_type;
   typedef logic signed [DEC_BITS-1:0]  dec_type;

   typedef enum logic {
      OP_START   = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   // Slope classes; each names the map into the first octant.
   typedef enum logic [1:0] {
      MODE_SHALLOW    = 2'd0,   // 0 <= m <= 1, identity
      MODE_STEEP      = 2'd1,   // m > 1 or vertical, swap x and y
      MODE_DOWN_STEEP = 2'd2,   // m < -1, x' = y, y' = -x
      MODE_DOWN       = 2'd3    // -1 <= m < 0, y' = -y
   } mode_type;

   typedef struct packed {
      logic     active;
      mode_type mode;
      walk_type walk_x;
      walk_type walk_y;
      walk_type stop_x;
      dec_type  decision;
      walk_type east_inc;
      walk_type northeast_inc;
   } line_state_type;

   typedef struct packed {
      logic      pixel_valid;
      coord_type pixel_x;
      coord_type pixel_y;
      logic      last_pixel;
   } pixel_type;

endpackage

FILE: src/mlr_if.sv
// Request and response channel interfaces of the line rasteriser.
interface mlr_req_if
   import mlr_pkg::*;
   ();
   logic      valid;
   logic      ready;
   op_type    operation;
   coord_type x_start;
   coord_type y_start;
   coord_type x_end;
   coord_type y_end;

   modport source (output valid, operation, x_start, y_start, x_end, y_end, input ready);
   modport sink   (input valid, operation, x_start, y_start, x_end, y_end, output ready);
endinterface

interface mlr_rsp_if
   import mlr_pkg::*;
   ();
   logic      valid;
   logic      ready;
   logic      pixel_valid;
   coord_type pixel_x;
   coord_type pixel_y;
   logic      last_pixel;

   modport source (output valid, pixel_valid, pixel_x, pixel_y, last_pixel, input ready);
   modport sink   (input valid, pixel_valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

FILE: src/mlr_setup.sv
// Line setup: slope class, octant map, endpoint order and decision terms.
module mlr_setup
   import mlr_pkg::*;
   (
   input  coord_type      x_start,
   input  coord_type      y_start,
   input  coord_type      x_end,
   input  coord_type      y_end,
   output line_state_type line_start
   );

   walk_type xs, ys, xe, ye;
   walk_type dx, dy, ndx, ndy;
   walk_type ax, ay, bx, by;
   walk_type lo_x, lo_y, hi_x, hi_y;
   walk_type ddx, ddy;
   mode_type mode;

   always_comb begin
      xs = $signed({2'b00, x_start});
      ys = $signed({2'b00, y_start});
      xe = $signed({2'b00, x_end});
      ye = $signed({2'b00, y_end});
      dx = xe - xs;
      dy = ye - ys;
      // direction-normalised slope terms, so the class needs no division
      ndx = dx[WALK_BITS-1] ? -dx : dx;
      ndy = dx[WALK_BITS-1] ? -dy : dy;

      if (dx == '0) begin
         mode = MODE_STEEP;
      end else if (!ndy[WALK_BITS-1] && ndy <= ndx) begin
         mode = MODE_SHALLOW;
      end else if (ndy > ndx) begin
         mode = MODE_STEEP;
      end else if (-ndy <= ndx) begin
         mode = MODE_DOWN;
      end else begin
         mode = MODE_DOWN_STEEP;
      end

      case (mode)
         MODE_SHALLOW: begin
            ax = xs; ay = ys;  bx = xe; by = ye;
         end
         MODE_STEEP: begin
            ax = ys; ay = xs;  bx = ye; by = xe;
         end
         MODE_DOWN_STEEP: begin
            ax = ys; ay = -xs; bx = ye; by = -xe;
         end
         default: begin
            ax = xs; ay = -ys; bx = xe; by = -ye;
         end
      endcase

      if (ax > bx) begin
         lo_x = bx; lo_y = by; hi_x = ax; hi_y = ay;
      end else begin
         lo_x = ax; lo_y = ay; hi_x = bx; hi_y = by;
      end
      ddx = hi_x - lo_x;
      ddy = hi_y - lo_y;

      line_start.active        = (lo_x < hi_x);
      line_start.mode          = mode;
      line_start.walk_x        = lo_x;
      line_start.walk_y        = lo_y;
      line_start.stop_x        = hi_x;
      line_start.decision      = dec_type'({ddy, 1'b0}) - dec_type'(ddx);
      line_start.east_inc      = walk_type'({ddy, 1'b0});
      line_start.northeast_inc = walk_type'({ddy - ddx, 1'b0});
   end

endmodule

FILE: src/midpoint_line_rasterizer_core.sv
// Midpoint line rasteriser for all eight octants, top level.
// A start item carries two endpoints and returns the first pixel of the line; each advance
// item returns the next pixel, with last_pixel set on the final one. An advance with no line
// active returns pixel_valid low and zero coordinates, and a start drops any line in progress.
// The line state is updated by a single add-and-compare step as the item is accepted and
// the pixel lands in the output register, so one item a cycle is sustained while the
// response side keeps taking results. The pixel is presented in the cycle after acceptance.
module midpoint_line_rasterizer_core
   import mlr_pkg::*;
   (
   input logic       clock,
   input logic       reset,
   mlr_req_if.sink   req,
   mlr_rsp_if.source rsp
   );

   line_state_type line_ff, line_in, line_start, line_step;
   logic           rsp_valid_ff, rsp_valid_in;
   pixel_type      pix_ff, pix_in;
   logic           req_accept;
   walk_type       neg_y;

   mlr_setup u_setup (
      .x_start    (req.x_start),
      .y_start    (req.y_start),
      .x_end      (req.x_end),
      .y_end      (req.y_end),
      .line_start (line_start)
   );

   assign req.ready  = !rsp_valid_ff || rsp.ready;
   assign req_accept = req.valid && req.ready;

   // one midpoint step in the first octant
   always_comb begin
      line_step = line_ff;
      if (line_ff.decision <= 0) begin
         line_step.decision = line_ff.decision + dec_type'(line_ff.east_inc);
      end else begin
         line_step.decision = line_ff.decision + dec_type'(line_ff.northeast_inc);
         line_step.walk_y   = line_ff.walk_y + walk_type'(1);
      end
      line_step.walk_x = line_ff.walk_x + walk_type'(1);
      line_step.active = !(line_step.walk_x >= line_ff.stop_x);
   end

   always_comb begin
      line_in = line_ff;
      pix_in  = '0;
      if (req.operation == OP_START) begin
         line_in = line_start;
      end else if (line_ff.active) begin
         line_in = line_step;
      end

      neg_y = -line_in.walk_y;
      if (req.operation == OP_START || line_ff.active) begin
         pix_in.pixel_valid = 1'b1;
         pix_in.last_pixel  = (line_in.walk_x >= line_in.stop_x);
         case (line_in.mode)
            MODE_SHALLOW: begin
               pix_in.pixel_x = line_in.walk_x[COORD_BITS-1:0];
               pix_in.pixel_y = line_in.walk_y[COORD_BITS-1:0];
            end
            MODE_STEEP: begin
               pix_in.pixel_x = line_in.walk_y[COORD_BITS-1:0];
               pix_in.pixel_y = line_in.walk_x[COORD_BITS-1:0];
            end
            MODE_DOWN_STEEP: begin
               pix_in.pixel_x = neg_y[COORD_BITS-1:0];
               pix_in.pixel_y = line_in.walk_x[COORD_BITS-1:0];
            end
            default: begin
               pix_in.pixel_x = line_in.walk_x[COORD_BITS-1:0];
               pix_in.pixel_y = neg_y[COORD_BITS-1:0];
            end
         endcase
      end
   end

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            line_ff <= line_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         pix_ff <= pix_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.pixel_valid = pix_ff.pixel_valid;
   assign rsp.pixel_x     = pix_ff.pixel_x;
   assign rsp.pixel_y     = pix_ff.pixel_y;
   assign rsp.last_pixel  = pix_ff.last_pixel;

endmodule

FILE: src/mlr_checker.sv
// Port-level assertions for the line rasteriser, bound to the top level.
module mlr_checker
   import mlr_pkg::*;
   (
   input logic      clock,
   input logic      reset,
   input logic      req_valid,
   input logic      req_ready,
   input op_type    req_operation,
   input coord_type req_x_start,
   input coord_type req_y_start,
   input coord_type req_x_end,
   input coord_type req_y_end,
   input logic      rsp_valid,
   input logic      rsp_ready,
   input logic      rsp_pixel_valid,
   input coord_type rsp_pixel_x,
   input coord_type rsp_pixel_y,
   input logic      rsp_last_pixel
   );

   logic start_accept;
   assign start_accept = req_valid && req_ready && req_operation == OP_START;

   // an empty output stage never blocks the request side
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("request stalled with empty output stage");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_x)
         && $stable(rsp_pixel_y) && $stable(rsp_last_pixel) && $stable(rsp_pixel_valid))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      start_accept |=> rsp_valid && rsp_pixel_valid)
      else $error("start item gave no pixel");

   // single-point line: the one pixel, marked last
   assert property (@(posedge clock) disable iff (reset)
      start_accept && req_x_start == req_x_end && req_y_start == req_y_end
      |=> rsp_last_pixel && rsp_pixel_x == $past(req_x_start)
         && rsp_pixel_y == $past(req_y_start))
      else $error("single-point line mis-drawn");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pixel_valid |-> rsp_pixel_x == '0 && rsp_pixel_y == '0
         && !rsp_last_pixel)
      else $error("invalid result carries data");

endmodule

bind midpoint_line_rasterizer_core mlr_checker u_mlr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .req_operation   (req.operation),
   .req_x_start     (req.x_start),
   .req_y_start     (req.y_start),
   .req_x_end       (req.x_end),
   .req_y_end       (req.y_end),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_pixel_valid (rsp.pixel_valid),
   .rsp_pixel_x     (rsp.pixel_x),
   .rsp_pixel_y     (rsp.pixel_y),
   .rsp_last_pixel  (rsp.last_pixel)
);
